>>> rtl/msl_pkg.sv
// ----------------------------------------------------------------------------
// msl_pkg
// types and constants shared by the mode select list checker modules
// ----------------------------------------------------------------------------
`default_nettype none

package msl_pkg;

    // width of the byte position counter (8 to 16)
    localparam int POS_W = 16;
    // page start is carried one bit wider than a 16-bit descriptor length sum
    localparam int PS_W  = 17;
    localparam int DL_W  = 16;

    localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};

    localparam logic [7:0]  FORMAT_PAGE_CODE  = 8'h03;
    localparam int          SHORT_HDR_LEN     = 4;
    localparam int          LONG_HDR_LEN      = 8;
    localparam int          SHORT_DL_POS      = 3;
    localparam int          LONG_DL_HI_POS    = 6;
    localparam int          LONG_DL_LO_POS    = 7;
    localparam int          FORMAT_MIN_LEN    = 12;
    localparam int          SIZE_HI_REL       = 12;
    localparam int          SIZE_LO_REL       = 13;
    localparam logic [15:0] BLK_SIZE_RESET    = 16'd512;

    typedef logic [2:0] err_t;

    localparam err_t ERR_NONE      = 3'd0;
    localparam err_t ERR_PF_CLEAR  = 3'd1;
    localparam err_t ERR_SHORT     = 3'd2;
    localparam err_t ERR_MISMATCH  = 3'd3;
    localparam err_t ERR_NO_FORMAT = 3'd4;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       first_byte;
        logic       last_byte;
        logic       long_form;
        logic       page_format;
    } req_t;

    typedef struct packed {
        logic accepted;
        err_t fail_reason;
    } res_t;

endpackage

`default_nettype wire

>>> rtl/mode_select_list_checker_top.sv
// ----------------------------------------------------------------------------
// mode_select_list_checker_top
// mode select parameter list checker, one list byte per request
// ----------------------------------------------------------------------------
// Takes one byte of a MODE SELECT(6)/(10) parameter list per request and gives
// one verdict on the byte marked last_byte. Each byte passes an input register,
// counter/compare logic that updates the list state, and, for a last byte, a
// result register that holds the verdict: a request can be taken every cycle
// while in_stall is low. A verdict held by out_stall stalls the input only
// once the next last byte reaches the input register; other bytes keep
// flowing. The block size that a format page must match is written through
// cfg_wr_en/cfg_wr_data (reset value 512); the user must write it only while
// no list is in flight, and the block itself does not enforce this.
// ----------------------------------------------------------------------------
`default_nettype none

module mode_select_list_checker_top
    import msl_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_wr_en,
    input  wire logic [15:0] cfg_wr_data,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  data_byte,
    input  wire logic        first_byte,
    input  wire logic        last_byte,
    input  wire logic        long_form,
    input  wire logic        page_format,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic             accepted,
    output logic [2:0]       fail_reason
);

    req_t in_req;
    req_t s1_req;
    logic s1_valid;
    logic s1_take;
    logic out_free;
    res_t verdict;
    res_t res_out;

    assign in_req.data_byte   = data_byte;
    assign in_req.first_byte  = first_byte;
    assign in_req.last_byte   = last_byte;
    assign in_req.long_form   = long_form;
    assign in_req.page_format = page_format;

    // only a last byte needs room in the result register
    assign s1_take = !s1_req.last_byte || out_free;

    msl_in_reg u_in_reg (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_req   (in_req),
        .s1_valid (s1_valid),
        .s1_req   (s1_req),
        .s1_take  (s1_take)
    );

    msl_parse u_parse (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s1_valid    (s1_valid),
        .s1_req      (s1_req),
        .step        (s1_take),
        .verdict     (verdict)
    );

    msl_out_reg u_out_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (s1_valid && s1_req.last_byte),
        .res_in    (verdict),
        .out_free  (out_free),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .res_out   (res_out)
    );

    assign accepted    = res_out.accepted;
    assign fail_reason = res_out.fail_reason;

endmodule

`default_nettype wire

>>> rtl/msl_in_reg.sv
// ----------------------------------------------------------------------------
// msl_in_reg
// input register stage for list bytes
// ----------------------------------------------------------------------------
`default_nettype none

module msl_in_reg
    import msl_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    output logic      in_stall,
    input  wire req_t in_req,
    output logic      s1_valid,
    output req_t      s1_req,
    input  wire logic s1_take
);

    logic s1_valid_reg;
    req_t s1_req_reg;

    // stage can refill while its current request moves on
    assign in_stall = s1_valid_reg && !s1_take;
    assign s1_valid = s1_valid_reg;
    assign s1_req   = s1_req_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall && in_valid)
        begin
            s1_req_reg <= in_req;
        end
    end

endmodule

`default_nettype wire

>>> rtl/msl_parse.sv
// ----------------------------------------------------------------------------
// msl_parse
// list walk state, format page checks and verdict logic
// ----------------------------------------------------------------------------
`default_nettype none

module msl_parse
    import msl_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_wr_en,
    input  wire logic [15:0] cfg_wr_data,
    input  wire logic        s1_valid,
    input  wire req_t        s1_req,
    input  wire logic        step,
    output res_t             verdict
);

    logic [15:0]      blk_size_reg;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [PS_W-1:0]  ps_reg, ps_next;
    logic [DL_W-1:0]  dl_reg, dl_next;
    logic [7:0]       code_reg, code_next;
    logic [7:0]       size_hi_reg, size_hi_next;
    logic             long_reg, long_next;
    logic             seen_reg, seen_next;
    err_t             err_reg, err_next;

    logic [POS_W-1:0] pos_cur;
    logic [DL_W-1:0]  dl_cur;
    logic [7:0]       b;
    logic             page_byte;
    logic [POS_W-1:0] rel;
    logic [PS_W-1:0]  hdr_len;

    always_comb
    begin
        b = s1_req.data_byte;

        // a first byte restarts the list before it is parsed
        if (s1_req.first_byte)
        begin
            pos_cur      = '0;
            ps_next      = '0;
            dl_cur       = '0;
            code_next    = '0;
            size_hi_next = '0;
            long_next    = s1_req.long_form;
            seen_next    = 1'b0;
            err_next     = s1_req.page_format ? ERR_NONE : ERR_PF_CLEAR;
        end
        else
        begin
            pos_cur      = pos_reg;
            ps_next      = ps_reg;
            dl_cur       = dl_reg;
            code_next    = code_reg;
            size_hi_next = size_hi_reg;
            long_next    = long_reg;
            seen_next    = seen_reg;
            err_next     = err_reg;
        end

        dl_next   = dl_cur;
        pos_next  = pos_cur;
        page_byte = 1'b0;
        rel       = '0;
        hdr_len   = long_next ? PS_W'(LONG_HDR_LEN) : PS_W'(SHORT_HDR_LEN);

        if (pos_cur != POS_MAX)
        begin
            // header: pick up the block descriptor length
            if (!long_next && pos_cur == POS_W'(SHORT_DL_POS))
            begin
                dl_next = {8'h00, b};
                ps_next = PS_W'(SHORT_HDR_LEN) + {{(PS_W-8){1'b0}}, b};
            end
            else if (long_next && pos_cur == POS_W'(LONG_DL_HI_POS))
            begin
                dl_next = {b, 8'h00};
            end
            else if (long_next && pos_cur == POS_W'(LONG_DL_LO_POS))
            begin
                dl_next = {dl_cur[15:8], b};
                ps_next = PS_W'(LONG_HDR_LEN) + {{(PS_W-DL_W){1'b0}}, dl_cur[15:8], b};
            end

            if ({{(PS_W-POS_W){1'b0}}, pos_cur} >= hdr_len
                && {{(PS_W-POS_W){1'b0}}, pos_cur} >= ps_next)
            begin
                page_byte = 1'b1;
                rel       = pos_cur - ps_next[POS_W-1:0];
                if (rel == '0)
                begin
                    code_next = b;
                end
                else
                begin
                    if (rel == POS_W'(1))
                    begin
                        dl_next = {8'h00, b};
                        if (code_next == FORMAT_PAGE_CODE && b < 8'(FORMAT_MIN_LEN)
                            && err_next == ERR_NONE)
                        begin
                            err_next = ERR_SHORT;
                        end
                    end
                    else if (rel == POS_W'(SIZE_HI_REL))
                    begin
                        size_hi_next = b;
                    end
                    else if (rel == POS_W'(SIZE_LO_REL) && code_next == FORMAT_PAGE_CODE)
                    begin
                        if ({size_hi_next, b} != blk_size_reg)
                        begin
                            if (err_next == ERR_NONE)
                            begin
                                err_next = ERR_MISMATCH;
                            end
                        end
                        else
                        begin
                            seen_next = 1'b1;
                        end
                    end
                    // end of page: next byte is the following page's code
                    if ({{(PS_W-POS_W){1'b0}}, rel} == {1'b0, dl_next} + PS_W'(1))
                    begin
                        ps_next = ps_next + {1'b0, dl_next} + PS_W'(2);
                    end
                end
            end
            pos_next = pos_cur + POS_W'(1);
        end

        if (s1_req.last_byte)
        begin
            // list ended inside a format page before its low size byte
            if (page_byte && code_next == FORMAT_PAGE_CODE && rel < POS_W'(SIZE_LO_REL)
                && err_next == ERR_NONE)
            begin
                err_next = ERR_SHORT;
            end
            if (err_next == ERR_NONE && !seen_next)
            begin
                err_next = ERR_NO_FORMAT;
            end
        end

        verdict.accepted    = (err_next == ERR_NONE);
        verdict.fail_reason = err_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blk_size_reg <= BLK_SIZE_RESET;
        end
        else if (cfg_wr_en)
        begin
            blk_size_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg     <= '0;
            ps_reg      <= '0;
            dl_reg      <= '0;
            code_reg    <= '0;
            size_hi_reg <= '0;
            long_reg    <= 1'b0;
            seen_reg    <= 1'b0;
            err_reg     <= ERR_NONE;
        end
        else if (s1_valid && step)
        begin
            pos_reg     <= pos_next;
            ps_reg      <= ps_next;
            dl_reg      <= dl_next;
            code_reg    <= code_next;
            size_hi_reg <= size_hi_next;
            long_reg    <= long_next;
            seen_reg    <= seen_next;
            err_reg     <= err_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/msl_out_reg.sv
// ----------------------------------------------------------------------------
// msl_out_reg
// result register holding one verdict until it is taken
// ----------------------------------------------------------------------------
`default_nettype none

module msl_out_reg
    import msl_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic load,
    input  wire res_t res_in,
    output logic      out_free,
    output logic      out_valid,
    input  wire logic out_stall,
    output res_t      res_out
);

    logic out_valid_reg;
    res_t res_reg;

    assign out_free  = !out_valid_reg || !out_stall;
    assign out_valid = out_valid_reg;
    assign res_out   = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= load;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free && load)
        begin
            res_reg <= res_in;
        end
    end

endmodule

`default_nettype wire

>>> test/tb_mode_select_list_checker_top.sv
// ----------------------------------------------------------------------------
// tb_mode_select_list_checker_top
// self-checking bench for the mode select parameter list checker
// ----------------------------------------------------------------------------
// Feeds six-byte and ten-byte parameter lists one byte per request. The lists
// are directed corner cases first, then random well-formed lists with some
// broken or stray ones mixed in. A predictor tracks the list state and queues
// the expected verdict for every last byte. Each verdict that leaves the block
// is compared with the oldest queued one. Sender and receiver idle at random.
// The receiver is held off once for a long stretch so the input backs up.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_mode_select_list_checker_top
    import msl_pkg::*;
();

    localparam int IDLE_LIMIT     = 4000;
    localparam int HOLD_CYCLES    = 150;

    logic        clk;
    logic        rst_n;
    logic        cfg_wr_en;
    logic [15:0] cfg_wr_data;
    logic        in_valid;
    logic        in_stall;
    logic [7:0]  data_byte;
    logic        first_byte;
    logic        last_byte;
    logic        long_form;
    logic        page_format;
    logic        out_valid;
    logic        out_stall;
    logic        accepted;
    logic [2:0]  fail_reason;

    // predictor copy of the configuration and the list state
    logic [15:0] sector_cfg;
    int unsigned byte_pos;
    int unsigned page_start;
    int unsigned run_len;
    logic [7:0]  page_code;
    logic [7:0]  size_hi;
    bit          is_long;
    bit          fmt_seen;
    err_t        err_latched;

    res_t        verdict_q[$];
    logic [7:0]  list_buf[$];

    int send_idle_pct;
    int recv_idle_pct;
    int hold_left;
    int idle_run;
    int errors;
    int bytes_sent;
    int verdicts_seen;
    int stall_cycles;

    mode_select_list_checker_top dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .data_byte   (data_byte),
        .first_byte  (first_byte),
        .last_byte   (last_byte),
        .long_form   (long_form),
        .page_format (page_format),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .accepted    (accepted),
        .fail_reason (fail_reason)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    function automatic void latch_err(input err_t code);
        if (err_latched == ERR_NONE)
            err_latched = code;
    endfunction

    function automatic void clear_list_state();
        byte_pos    = 0;
        page_start  = 0;
        run_len     = 0;
        page_code   = 8'h00;
        size_hi     = 8'h00;
        is_long     = 1'b0;
        fmt_seen    = 1'b0;
        err_latched = ERR_NONE;
    endfunction

    // advances the list state by one byte; returns 1 when a verdict is due
    function automatic bit parse_list_byte(input req_t r, output res_t verdict);
        int unsigned p;
        int unsigned hdr_len;
        int unsigned rel;
        int unsigned d;
        bit          page_byte;
        page_byte = 1'b0;
        rel       = 0;
        verdict   = '0;
        d         = {24'h000000, r.data_byte};
        if (r.first_byte)
        begin
            clear_list_state();
            is_long = r.long_form;
            if (!r.page_format)
                latch_err(ERR_PF_CLEAR);
        end
        if (byte_pos < POS_MAX)
        begin
            p       = byte_pos;
            hdr_len = is_long ? LONG_HDR_LEN : SHORT_HDR_LEN;
            if (!is_long && p == SHORT_DL_POS)
            begin
                run_len    = d;
                page_start = SHORT_HDR_LEN + d;
            end
            else if (is_long && p == LONG_DL_HI_POS)
                run_len = {16'h0000, r.data_byte, 8'h00};
            else if (is_long && p == LONG_DL_LO_POS)
            begin
                run_len    = (run_len & 32'hFF00) | d;
                page_start = LONG_HDR_LEN + run_len;
            end
            if (p >= hdr_len && p >= page_start)
            begin
                page_byte = 1'b1;
                rel       = p - page_start;
                if (rel == 0)
                    page_code = r.data_byte;
                else
                begin
                    if (rel == 1)
                    begin
                        run_len = d;
                        if (page_code == FORMAT_PAGE_CODE && d < FORMAT_MIN_LEN)
                            latch_err(ERR_SHORT);
                    end
                    else if (rel == SIZE_HI_REL)
                        size_hi = r.data_byte;
                    else if (rel == SIZE_LO_REL && page_code == FORMAT_PAGE_CODE)
                    begin
                        if ({size_hi, r.data_byte} != sector_cfg)
                            latch_err(ERR_MISMATCH);
                        else
                            fmt_seen = 1'b1;
                    end
                    // page spans its length byte plus two
                    if (rel == run_len + 1)
                        page_start = (page_start + run_len + 2) & 32'h1FFFF;
                end
            end
            byte_pos = p + 1;
        end
        if (!r.last_byte)
            return 1'b0;
        if (page_byte && page_code == FORMAT_PAGE_CODE && rel < SIZE_LO_REL)
            latch_err(ERR_SHORT);
        if (err_latched == ERR_NONE && !fmt_seen)
            latch_err(ERR_NO_FORMAT);
        verdict.accepted    = (err_latched == ERR_NONE);
        verdict.fail_reason = err_latched;
        return 1'b1;
    endfunction

    function automatic logic [7:0] rand_byte();
        return 8'($urandom_range(255));
    endfunction

    // ---------------------------------------------------------------- list building

    task automatic add_header(input bit lf, input int unsigned dl);
        if (lf)
        begin
            repeat (6) list_buf.push_back(rand_byte());
            list_buf.push_back(dl[15:8]);
            list_buf.push_back(dl[7:0]);
        end
        else
        begin
            repeat (3) list_buf.push_back(rand_byte());
            list_buf.push_back(dl[7:0]);
        end
        // descriptors only for lengths that keep the list short
        if (dl <= 64)
            repeat (dl) list_buf.push_back(rand_byte());
    endtask

    task automatic add_format_page(input int len, input logic [15:0] size);
        list_buf.push_back(FORMAT_PAGE_CODE);
        list_buf.push_back(len[7:0]);
        for (int rel = 2; rel <= len + 1; rel++)
        begin
            if (rel == SIZE_HI_REL)
                list_buf.push_back(size[15:8]);
            else if (rel == SIZE_LO_REL)
                list_buf.push_back(size[7:0]);
            else
                list_buf.push_back(rand_byte());
        end
    endtask

    task automatic add_other_page(input int len);
        logic [7:0] code;
        code = rand_byte();
        if (code == FORMAT_PAGE_CODE)
            code = ~code;
        list_buf.push_back(code);
        list_buf.push_back(len[7:0]);
        repeat (len) list_buf.push_back(rand_byte());
    endtask

    task automatic cut_list(input int n);
        while (list_buf.size() > n)
            void'(list_buf.pop_back());
    endtask

    // ---------------------------------------------------------------- driving

    task automatic offer_byte(input req_t r);
        res_t verdict;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid    <= 1'b1;
        data_byte   <= r.data_byte;
        first_byte  <= r.first_byte;
        last_byte   <= r.last_byte;
        long_form   <= r.long_form;
        page_format <= r.page_format;
        do
            @(posedge clk);
        while (in_stall);
        if (parse_list_byte(r, verdict))
            verdict_q.push_back(verdict);
        bytes_sent++;
        @(negedge clk);
    endtask

    // sends list_buf; without new_list the bytes continue the current list
    task automatic send_list(input bit lf, input bit pf, input bit new_list);
        req_t r;
        for (int i = 0; i < list_buf.size(); i++)
        begin
            r.data_byte   = list_buf[i];
            r.first_byte  = new_list && (i == 0);
            r.last_byte   = (i == list_buf.size() - 1);
            r.long_form   = r.first_byte ? lf : 1'($urandom_range(1));
            r.page_format = r.first_byte ? pf : 1'($urandom_range(1));
            offer_byte(r);
        end
        list_buf.delete();
    endtask

    task automatic drain_verdicts();
        in_valid <= 1'b0;
        while (verdict_q.size() != 0)
            @(posedge clk);
        // let any byte without a verdict clear the pipeline
        repeat (4) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_blk_size(input logic [15:0] value);
        drain_verdicts();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
        sector_cfg = value;
    endtask

    // ---------------------------------------------------------------- tests

    // bytes before any first byte form a six-byte list with no pf check
    task automatic test_stray_bytes();
        add_header(1'b0, 0);
        add_format_page(12, 16'h0200);
        send_list(1'b0, 1'b0, 1'b0);
        // more bytes after a last byte give a fresh verdict on the same list
        list_buf.push_back(rand_byte());
        list_buf.push_back(rand_byte());
        send_list(1'b0, 1'b0, 1'b0);
    endtask

    task automatic test_error_cases();
        // pf clear on a list that ends in its header
        list_buf.push_back(rand_byte());
        send_list(1'b0, 1'b0, 1'b1);
        // pf clear wins over a later size mismatch
        add_header(1'b0, 0);
        add_format_page(12, 16'h0201);
        send_list(1'b0, 1'b0, 1'b1);
        // ten-byte list ending inside the header, then inside the descriptors
        repeat (5) list_buf.push_back(rand_byte());
        send_list(1'b1, 1'b1, 1'b1);
        add_header(1'b1, 8);
        cut_list(12);
        send_list(1'b1, 1'b1, 1'b1);
        // format page declared shorter than the size field
        add_header(1'b0, 0);
        add_format_page(5, 16'h0200);
        add_other_page(2);
        send_list(1'b0, 1'b1, 1'b1);
        // format page cut off before its low size byte
        add_header(1'b0, 0);
        add_format_page(20, 16'h0200);
        cut_list(SHORT_HDR_LEN + SIZE_LO_REL);
        send_list(1'b0, 1'b1, 1'b1);
        add_header(1'b0, 0);
        add_format_page(12, 16'h0201);
        send_list(1'b0, 1'b1, 1'b1);
        // only other pages
        add_header(1'b0, 0);
        add_other_page(4);
        add_other_page(0);
        send_list(1'b0, 1'b1, 1'b1);
    endtask

    task automatic test_long_form_list();
        add_header(1'b1, 8);
        add_other_page(3);
        add_format_page(22, 16'h0200);
        send_list(1'b1, 1'b1, 1'b1);
    endtask

    task automatic test_blk_size_extremes();
        write_blk_size(16'h0000);
        add_header(1'b0, 0);
        add_format_page(12, 16'h0000);
        send_list(1'b0, 1'b1, 1'b1);
        write_blk_size(16'hFFFF);
        add_header(1'b1, 0);
        add_format_page(13, 16'hFFFF);
        send_list(1'b1, 1'b1, 1'b1);
        add_header(1'b0, 0);
        add_format_page(12, 16'h0000);
        send_list(1'b0, 1'b1, 1'b1);
    endtask

    task automatic test_random_lists(input int byte_goal, input int list_goal);
        int start_bytes;
        int lists;
        int roll;
        bit lf;
        bit pf;
        start_bytes = bytes_sent;
        lists       = 0;
        while (bytes_sent - start_bytes < byte_goal || lists < list_goal)
        begin
            roll = $urandom_range(99);
            lf   = 1'($urandom_range(1));
            pf   = ($urandom_range(99) < 92);
            if (roll < 5)
            begin
                // stray bytes continuing whatever list came before
                repeat ($urandom_range(4, 1)) list_buf.push_back(rand_byte());
                send_list(lf, pf, 1'b0);
            end
            else if (roll < 10)
            begin
                // descriptor length too large for any page to be reached
                add_header(lf, lf ? $urandom_range(65535, 65) : $urandom_range(255, 65));
                repeat ($urandom_range(3)) list_buf.push_back(rand_byte());
                cut_list($urandom_range(list_buf.size(), 1));
                send_list(lf, pf, 1'b1);
            end
            else
            begin
                add_header(lf, ($urandom_range(99) < 70) ? 0 : $urandom_range(8));
                if ($urandom_range(99) < 30)
                    add_other_page($urandom_range(3));
                if ($urandom_range(99) < 85)
                    add_format_page(($urandom_range(99) < 90) ? $urandom_range(14, 12)
                                                              : $urandom_range(11),
                                    ($urandom_range(99) < 80) ? sector_cfg
                                                              : 16'($urandom_range(65535)));
                if ($urandom_range(99) < 20)
                    add_other_page($urandom_range(3));
                if ($urandom_range(99) < 15)
                    cut_list($urandom_range(list_buf.size(), 1));
                send_list(lf, pf, 1'b1);
            end
            lists++;
        end
    endtask

    // receiver holds off while one-byte lists keep coming, so the block backs up
    task automatic test_backpressure();
        in_valid <= 1'b0;
        @(posedge clk);
        hold_left = HOLD_CYCLES;
        @(negedge clk);
        repeat (40)
        begin
            list_buf.push_back(rand_byte());
            send_list(1'($urandom_range(1)), 1'($urandom_range(1)), 1'b1);
        end
    endtask

    // ---------------------------------------------------------------- receiver side

    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left--;
        end
        else
            out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    always @(posedge clk)
    begin : check_verdict
        res_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (verdict_q.size() == 0)
            begin
                $display("%0t: verdict with none pending: accepted %0d fail_reason %0d",
                         $time, accepted, fail_reason);
                errors++;
            end
            else
            begin
                want = verdict_q.pop_front();
                if (accepted !== want.accepted)
                begin
                    $display("%0t: accepted: expected %0d, got %0d",
                             $time, want.accepted, accepted);
                    errors++;
                end
                if (fail_reason !== want.fail_reason)
                begin
                    $display("%0t: fail_reason: expected %0d, got %0d",
                             $time, want.fail_reason, fail_reason);
                    errors++;
                end
                verdicts_seen++;
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || cfg_wr_en || (in_valid && !in_stall) || (out_valid && !out_stall))
            idle_run = 0;
        else
            idle_run++;
        if (rst_n && in_stall)
            stall_cycles++;
        if (idle_run >= IDLE_LIMIT)
        begin
            $display("%0t: no request moved for %0d cycles", $time, IDLE_LIMIT);
            $display("tb_mode_select_list_checker_top NOT OK");
            $finish;
        end
    end

    initial
    begin
        rst_n         = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_wr_data   = 16'h0000;
        in_valid      = 1'b0;
        data_byte     = 8'h00;
        first_byte    = 1'b0;
        last_byte     = 1'b0;
        long_form     = 1'b0;
        page_format   = 1'b0;
        out_stall     = 1'b0;
        hold_left     = 0;
        idle_run      = 0;
        errors        = 0;
        bytes_sent    = 0;
        verdicts_seen = 0;
        stall_cycles  = 0;
        sector_cfg    = BLK_SIZE_RESET;
        clear_list_state();
        send_idle_pct = 30;
        recv_idle_pct = 65;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_stray_bytes();
        test_error_cases();
        test_long_form_list();
        test_blk_size_extremes();

        write_blk_size(16'($urandom_range(65535)));
        test_random_lists(120, 12);

        send_idle_pct = 65;
        recv_idle_pct = 30;
        write_blk_size(16'($urandom_range(65535)));
        test_random_lists(120, 12);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_blk_size(BLK_SIZE_RESET);
        test_random_lists(120, 12);
        test_backpressure();

        drain_verdicts();
        repeat (8) @(posedge clk);
        if (verdict_q.size() != 0)
        begin
            $display("%0t: %0d verdicts never arrived", $time, verdict_q.size());
            errors++;
        end
        $display("sent %0d list bytes, checked %0d verdicts, input held off for %0d cycles",
                 bytes_sent, verdicts_seen, stall_cycles);
        $display("six- and ten-byte lists, every fail reason, stray lists, long receiver hold");
        if (errors == 0)
            $display("tb_mode_select_list_checker_top OK");
        else
            $display("tb_mode_select_list_checker_top NOT OK");
        $finish;
    end

endmodule

`default_nettype wire
